// File: rtl/wmalu_pkg.sv
// ----------------------------------------------------------------------------
// wmalu_pkg: shared definitions for the wide magnitude ALU
// Operation codes, comparison codes, field widths and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package wmalu_pkg;

  // Field widths of the split operand ports
  localparam int LOW_W  = 64;
  localparam int HIGH_W = 32;
  localparam int FLD_W  = LOW_W + HIGH_W;

  // Operation codes
  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  // Magnitude comparison codes
  localparam logic [1:0] ORD_EQ = 2'd0;
  localparam logic [1:0] ORD_GT = 2'd1;
  localparam logic [1:0] ORD_LT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new transaction's operands
    logic step;   // one add/subtract, or one multiply or divide iteration
    logic store;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic long_op;  // operation at the input needs one iteration per bit
  } status_t;

endpackage

// File: rtl/wmalu_ctrl.sv
// ----------------------------------------------------------------------------
// wmalu_ctrl: sequencing controller
// Accepts one transaction at a time, counts iterations and hands the result
// to the output register when that register is free.
// ----------------------------------------------------------------------------
module wmalu_ctrl #(
  parameter int WIDTH = 96
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wmalu_pkg::status_t status,
  output wmalu_pkg::cmd_t    cmd
);

  localparam int CW = $clog2(WIDTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          out_valid_next;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state, iteration count and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          count_next = status.long_op ? CW'(WIDTH) : CW'(1);
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step   = 1'b1;
        count_next = count - CW'(1);
        if (count == CW'(1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.store  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: set by a store, cleared when the result is taken
  always_comb begin
    priority if (cmd.store) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RUN && count != '0))
    else $error("accepted transaction did not start with a nonzero count");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (count != '0))
    else $error("iteration count reached zero while running");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN && out_valid))
    else $error("finished result lost while output stalled");

  a_store_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (out_valid && state == S_IDLE))
    else $error("store did not present a result");
`endif

endmodule

// File: rtl/wmalu_dp.sv
// ----------------------------------------------------------------------------
// wmalu_dp: arithmetic datapath
// Operand and accumulator registers, one adder path per operation, shift
// registers for shift-and-add multiply and restoring divide, output register.
// ----------------------------------------------------------------------------
module wmalu_dp #(
  parameter int WIDTH = 96
) (
  input  logic               clk,
  input  wmalu_pkg::cmd_t    cmd,
  output wmalu_pkg::status_t status,
  input  logic [1:0]         func,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [WIDTH-1:0]   value,
  output logic [WIDTH-1:0]   rest,
  output logic               carry_out,
  output logic               div_zero,
  output logic [1:0]         order
);

  // Working registers
  logic [1:0]       func_r;
  logic [WIDTH-1:0] x, x_next;      // a, multiplicand part, or dividend/quotient
  logic [WIDTH-1:0] y, y_next;      // b, multiplier bits, or divisor
  logic [WIDTH-1:0] acc, acc_next;  // sum, difference or product
  logic [WIDTH-1:0] rem, rem_next;  // partial remainder
  logic             lost, lost_next;
  logic             cy, cy_next;
  logic             dz;
  logic [1:0]       ord;

  logic             b_zero;
  logic [WIDTH:0]   sum, diff, madd;
  logic [WIDTH-1:0] rs;
  logic [WIDTH+1:0] dsub;

  assign b_zero         = (b == '0);
  assign status.long_op = (func == wmalu_pkg::FN_MUL) ||
                          ((func == wmalu_pkg::FN_DIV) && !b_zero);

  // Arithmetic paths
  assign sum  = {1'b0, x} + {1'b0, y};
  assign diff = {1'b0, x} - {1'b0, y};
  assign madd = {1'b0, acc} + {1'b0, x};
  assign rs   = {rem[WIDTH-2:0], x[WIDTH-1]};
  assign dsub = {1'b0, rem[WIDTH-1], rs} - {2'b00, y};

  // One step of the selected operation
  always_comb begin
    x_next    = x;
    y_next    = y;
    acc_next  = acc;
    rem_next  = rem;
    lost_next = lost;
    cy_next   = cy;
    unique case (func_r)
      wmalu_pkg::FN_ADD: begin
        acc_next = sum[WIDTH-1:0];
        cy_next  = sum[WIDTH];
      end
      wmalu_pkg::FN_SUB: begin
        acc_next = diff[WIDTH-1:0];
        cy_next  = diff[WIDTH];
      end
      wmalu_pkg::FN_MUL: begin
        if (y[0]) begin
          acc_next = madd[WIDTH-1:0];
          cy_next  = cy | madd[WIDTH] | lost;
        end
        x_next    = {x[WIDTH-2:0], 1'b0};
        y_next    = {1'b0, y[WIDTH-1:1]};
        lost_next = lost | x[WIDTH-1];
      end
      wmalu_pkg::FN_DIV: begin
        if (dz) begin
          // zero divisor: quotient 0, remainder is the dividend
          rem_next = x;
          x_next   = '0;
        end else if (!dsub[WIDTH+1]) begin
          rem_next = dsub[WIDTH-1:0];
          x_next   = {x[WIDTH-2:0], 1'b1};
        end else begin
          rem_next = rs;
          x_next   = {x[WIDTH-2:0], 1'b0};
        end
      end
      default: begin
        x_next = x;
      end
    endcase
  end

  // Working registers: load or step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      x      <= a;
      y      <= b;
      acc    <= '0;
      rem    <= '0;
      lost   <= 1'b0;
      cy     <= 1'b0;
      dz     <= (func == wmalu_pkg::FN_DIV) && b_zero;
      priority if (a == b) begin
        ord <= wmalu_pkg::ORD_EQ;
      end else if (a > b) begin
        ord <= wmalu_pkg::ORD_GT;
      end else begin
        ord <= wmalu_pkg::ORD_LT;
      end
    end else if (cmd.step) begin
      x    <= x_next;
      y    <= y_next;
      acc  <= acc_next;
      rem  <= rem_next;
      lost <= lost_next;
      cy   <= cy_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      value     <= (func_r == wmalu_pkg::FN_DIV) ? x : acc;
      rest      <= rem;
      carry_out <= cy;
      div_zero  <= dz;
      order     <= ord;
    end
  end

endmodule

// File: rtl/wide_magnitude_alu_96_unit.sv
// ----------------------------------------------------------------------------
// wide_magnitude_alu_96_unit: 96-bit unsigned magnitude ALU
// Add, subtract, shift-and-add multiply and restoring divide with a
// three-way magnitude comparison of the operands delivered with every result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries func and the split operands
//   a_low/a_high and b_low/b_high. Output channel (out_valid/out_ready)
//   carries value, remainder, carry/borrow/overflow, div_zero and order.
//   One result per input transaction, in order.
// Sequence (accept to result valid):
//   add, subtract, divide by zero: a single step, then a store.
//   multiply, divide: one step per operand bit, then a store; the iteration
//   counter steps the shared shift/add-subtract datapath once per bit.
// Occupancy: one transaction in flight; the next is accepted once the
//   result has moved to the output register.
// Stall: a finished result waits in the output register; the following
//   transaction may be accepted and computed meanwhile, and it then holds
//   until the output register is freed.
// Reset: rst (synchronous) empties the output register and returns the
//   controller to idle; no result is pending afterwards.
// ----------------------------------------------------------------------------
module wide_magnitude_alu_96_unit #(
  parameter int WIDTH = 96
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [wmalu_pkg::LOW_W-1:0]   a_low,
  input  logic [wmalu_pkg::HIGH_W-1:0]  a_high,
  input  logic [wmalu_pkg::LOW_W-1:0]   b_low,
  input  logic [wmalu_pkg::HIGH_W-1:0]  b_high,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wmalu_pkg::LOW_W-1:0]   value_low,
  output logic [wmalu_pkg::HIGH_W-1:0]  value_high,
  output logic [wmalu_pkg::LOW_W-1:0]   rest_low,
  output logic [wmalu_pkg::HIGH_W-1:0]  rest_high,
  output logic                          carry_out,
  output logic                          div_zero,
  output logic [1:0]                    order
);

  localparam int EXT_W = WIDTH + wmalu_pkg::FLD_W;

  wmalu_pkg::cmd_t    cmd;
  wmalu_pkg::status_t status;

  logic [EXT_W-1:0] a_ext, b_ext, value_ext, rest_ext;
  logic [WIDTH-1:0] a, b, value, rest;

  // Operands: 96 input bits fitted to WIDTH (zero above bit 95)
  assign a_ext = {{WIDTH{1'b0}}, a_high, a_low};
  assign b_ext = {{WIDTH{1'b0}}, b_high, b_low};
  assign a     = a_ext[WIDTH-1:0];
  assign b     = b_ext[WIDTH-1:0];

  // Results: WIDTH bits fitted to the 96-bit output fields
  assign value_ext  = {{wmalu_pkg::FLD_W{1'b0}}, value};
  assign rest_ext   = {{wmalu_pkg::FLD_W{1'b0}}, rest};
  assign value_low  = value_ext[wmalu_pkg::LOW_W-1:0];
  assign value_high = value_ext[wmalu_pkg::FLD_W-1:wmalu_pkg::LOW_W];
  assign rest_low   = rest_ext[wmalu_pkg::LOW_W-1:0];
  assign rest_high  = rest_ext[wmalu_pkg::FLD_W-1:wmalu_pkg::LOW_W];

  wmalu_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wmalu_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .func      (func),
    .a         (a),
    .b         (b),
    .value     (value),
    .rest      (rest),
    .carry_out (carry_out),
    .div_zero  (div_zero),
    .order     (order)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for wide_magnitude_alu_96_unit
// Drives add, subtract, multiply and divide transactions through the
// valid/ready input channel. A scoreboard predicts each result from the
// accepted operands using native wide arithmetic. Every output transaction
// is checked field by field against the oldest prediction. Idle and stall
// patterns change from phase to phase, and one long output hold-off fills
// the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WIDTH          = 96;
  localparam int PHASE_ITEMS    = 490;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  // Expected contents of one output transaction
  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] rest;
    logic             carry;
    logic             div_zero;
    logic [1:0]       ord;
  } alu_result_t;

  // Scoreboard: predicts results of accepted operands, checks delivered ones
  class alu_scoreboard;
    alu_result_t due_results[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Predict the result of one accepted transaction
    function void note_operands(logic [1:0] fn, logic [WIDTH-1:0] a,
                                logic [WIDTH-1:0] b);
      alu_result_t      r;
      logic [WIDTH:0]   sum;
      logic [2*WIDTH-1:0] product;
      r = '0;
      case (fn)
        wmalu_pkg::FN_ADD: begin
          sum = {1'b0, a} + {1'b0, b};
          r.value = sum[WIDTH-1:0];
          r.carry = sum[WIDTH];
        end
        wmalu_pkg::FN_SUB: begin
          r.value = a - b;
          r.carry = (a < b);
        end
        wmalu_pkg::FN_MUL: begin
          product = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
          r.value = product[WIDTH-1:0];
          r.carry = |product[2*WIDTH-1:WIDTH];
        end
        default: begin
          // divide by zero: flag, zero quotient, remainder is the dividend
          if (b == '0) begin
            r.div_zero = 1'b1;
            r.rest = a;
          end else begin
            r.value = a / b;
            r.rest = a % b;
          end
        end
      endcase
      r.ord = (a == b) ? wmalu_pkg::ORD_EQ :
              ((a > b) ? wmalu_pkg::ORD_GT : wmalu_pkg::ORD_LT);
      due_results.push_back(r);
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_result(alu_result_t got);
      alu_result_t want;
      bit bad;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: value=%h rest=%h carry=%b dz=%b order=%0d",
                   got.value, got.rest, got.carry, got.div_zero, got.ord);
        return;
      end
      want = due_results.pop_front();
      bad = 0;
      if (got.value !== want.value) bad = 1;
      if (got.rest !== want.rest) bad = 1;
      if (got.carry !== want.carry) bad = 1;
      if (got.div_zero !== want.div_zero) bad = 1;
      if (got.ord !== want.ord) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch exp: value=%h rest=%h carry=%b dz=%b order=%0d",
                   want.value, want.rest, want.carry, want.div_zero, want.ord);
          $display("         got: value=%h rest=%h carry=%b dz=%b order=%0d",
                   got.value, got.rest, got.carry, got.div_zero, got.ord);
        end
      end
    endfunction
  endclass

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = wmalu_pkg::FN_ADD;
  logic [wmalu_pkg::LOW_W-1:0] a_low = '0;
  logic [wmalu_pkg::HIGH_W-1:0] a_high = '0;
  logic [wmalu_pkg::LOW_W-1:0] b_low = '0;
  logic [wmalu_pkg::HIGH_W-1:0] b_high = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [wmalu_pkg::LOW_W-1:0] value_low;
  logic [wmalu_pkg::HIGH_W-1:0] value_high;
  logic [wmalu_pkg::LOW_W-1:0] rest_low;
  logic [wmalu_pkg::HIGH_W-1:0] rest_high;
  logic carry_out;
  logic div_zero;
  logic [1:0] order;

  alu_scoreboard sb;
  int unsigned in_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  bit hold_req = 0;
  int unsigned idle_cycles = 0;

  wide_magnitude_alu_96_unit #(.WIDTH(WIDTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .a_low(a_low), .a_high(a_high), .b_low(b_low), .b_high(b_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .value_low(value_low), .value_high(value_high),
    .rest_low(rest_low), .rest_high(rest_high),
    .carry_out(carry_out), .div_zero(div_zero), .order(order)
  );

  always #2 clk = ~clk;

  // Monitors: note accepted inputs, check accepted outputs
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_operands(func, {a_high, a_low}, {b_high, b_low});
    if (!rst && out_valid && out_ready)
      sb.check_result('{value: {value_high, value_low}, rest: {rest_high, rest_low},
                        carry: carry_out, div_zero: div_zero, ord: order});
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[wide_magnitude_alu_96_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Offer one transaction and return at the edge that accepts it
  task automatic send_op(logic [1:0] fn, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    a_low <= a[wmalu_pkg::LOW_W-1:0];
    a_high <= a[WIDTH-1:wmalu_pkg::LOW_W];
    b_low <= b[wmalu_pkg::LOW_W-1:0];
    b_high <= b[WIDTH-1:wmalu_pkg::LOW_W];
    do @(posedge clk); while (!in_ready);
  endtask

  // Operand with a spread of magnitudes and corner values
  function automatic logic [WIDTH-1:0] rand_operand();
    logic [WIDTH-1:0] v;
    v = {$urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = {{(WIDTH-1){1'b0}}, 1'b1} << $urandom_range(WIDTH-1);
      3, 4: v = v >> $urandom_range(WIDTH-1);
      5: v = v & 96'hFFFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random();
    logic [WIDTH-1:0] a, b;
    a = rand_operand();
    b = rand_operand();
    case ($urandom_range(15))
      0, 1: b = a;
      2: b = a + 1;
      3: b = a - 1;
      default: ;
    endcase
    send_op(2'($urandom_range(3)), a, b);
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  localparam logic [WIDTH-1:0] ALL_ONES = '1;
  localparam logic [WIDTH-1:0] TOP_BIT  = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] LOW_MAX  = {{wmalu_pkg::HIGH_W{1'b0}},
                                           {wmalu_pkg::LOW_W{1'b1}}};

  // Main sequence
  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners
    send_op(wmalu_pkg::FN_ADD, '0, '0);
    send_op(wmalu_pkg::FN_ADD, ALL_ONES, ALL_ONES);
    send_op(wmalu_pkg::FN_ADD, ALL_ONES, 96'd1);
    send_op(wmalu_pkg::FN_ADD, LOW_MAX, 96'd1);
    send_op(wmalu_pkg::FN_SUB, '0, '0);
    send_op(wmalu_pkg::FN_SUB, '0, 96'd1);
    send_op(wmalu_pkg::FN_SUB, ALL_ONES, ALL_ONES);
    send_op(wmalu_pkg::FN_SUB, TOP_BIT, LOW_MAX);
    send_op(wmalu_pkg::FN_MUL, '0, ALL_ONES);
    send_op(wmalu_pkg::FN_MUL, ALL_ONES, ALL_ONES);
    send_op(wmalu_pkg::FN_MUL, TOP_BIT, 96'd2);
    send_op(wmalu_pkg::FN_MUL, 96'd1 << 48, 96'd1 << 47);
    send_op(wmalu_pkg::FN_MUL, 96'd1, ALL_ONES);
    send_op(wmalu_pkg::FN_MUL, LOW_MAX, LOW_MAX);
    send_op(wmalu_pkg::FN_DIV, ALL_ONES, '0);
    send_op(wmalu_pkg::FN_DIV, '0, '0);
    send_op(wmalu_pkg::FN_DIV, 96'd5, 96'd7);
    send_op(wmalu_pkg::FN_DIV, ALL_ONES, 96'd1);
    send_op(wmalu_pkg::FN_DIV, ALL_ONES, ALL_ONES);
    send_op(wmalu_pkg::FN_DIV, TOP_BIT, 96'd3);
    send_op(wmalu_pkg::FN_DIV, ALL_ONES, TOP_BIT);
    send_op(wmalu_pkg::FN_DIV, '0, 96'd5);
    send_op(wmalu_pkg::FN_DIV, 96'h1234_5678_9abc_def0_1122_3344, 96'hffff_ffff);
    drain();

    // Random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 75; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 75; end
        default: begin in_gap_pct = 7; out_stall_pct = 7; end
      endcase
      // long output hold-off while inputs keep coming
      if (ph == 0) hold_req = 1;
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    repeat (2 * WIDTH) @(posedge clk);
    if (sb.due_results.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("[wide_magnitude_alu_96_unit] OK");
    else
      $display("[wide_magnitude_alu_96_unit] ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/wmalu_pkg.sv
rtl/wmalu_ctrl.sv
rtl/wmalu_dp.sv
rtl/wide_magnitude_alu_96_unit.sv
tb/tb_top.sv
